// ===== hw/rtl/cansr_pkg.sv =====
// shared constants for the can segment reassembler
// sizes of the assembly store, frame fields and stream words; no dependencies
`default_nettype none
package cansr_pkg;
    localparam int BUFFER_BYTES  = 64;
    localparam int MESSAGE_BYTES = 32;
    localparam int CHUNK_BYTES   = 7;

    localparam int BYTE_W     = 8;
    localparam int SEG_W      = 7;
    localparam int EXP_W      = 8;
    localparam int PAYLOAD_W  = CHUNK_BYTES * BYTE_W;
    localparam int IDX_W      = 6;
    localparam int ADDR_W     = $clog2(BUFFER_BYTES);
    localparam int FILL_W     = $clog2(BUFFER_BYTES + 1);
    localparam int SUM_W      = $clog2(BUFFER_BYTES + CHUNK_BYTES + 1);
    localparam int KCNT_W     = $clog2(CHUNK_BYTES);

    localparam int IN_TDATA_W  = ((SEG_W + PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((BYTE_W + IDX_W + 7) / 8) * 8;
endpackage
`default_nettype wire

// ===== hw/rtl/can_segment_reassembler.sv =====
// can segment reassembler top level: frame intake, store write sweep, byte readout
// intake: an appended frame holds the input while it is accepted and its 7 bytes are stored,
// one byte per cycle on the single ram write port; an ignored frame is only accepted
// readout: each message byte is read, loaded and then held until the output takes it
// reset (i_rst_n low, synchronous) clears sequencer and message state, not the store
// depends on cansr_pkg and cansr_ram
`default_nettype none
module can_segment_reassembler (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave side: tdata = segment_number[6:0], payload[62:7], zero pad [63]
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [cansr_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire logic                                i_s_tlast,   // last_segment
    // master side: tdata = message_byte[7:0], byte_index[13:8], zero pad [15:14]
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic      [cansr_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                                     o_m_tlast    // final_byte
);
    import cansr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_LOAD,
        S_HOLD
    } t_state;

    t_state                r_state;
    logic [FILL_W-1:0]     r_fill;
    logic [EXP_W-1:0]      r_exp;
    logic                  r_asm;
    logic                  r_emit;
    logic [FILL_W-1:0]     r_base;
    logic [KCNT_W-1:0]     r_k;
    logic [PAYLOAD_W-1:0]  r_payload;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_m_valid;
    logic [BYTE_W-1:0]     r_m_byte;
    logic [IDX_W-1:0]      r_m_idx;
    logic                  r_m_last;

    logic [SEG_W-1:0]      seg;
    logic [PAYLOAD_W-1:0]  payload;
    logic                  restart;
    logic [FILL_W-1:0]     eff_fill;
    logic [EXP_W-1:0]      eff_exp;
    logic                  eff_asm;
    logic                  seg_match;
    logic [SUM_W-1:0]      sum;
    logic                  fits;
    logic                  enough;
    logic                  s_xfer;
    logic                  m_xfer;
    logic                  we;
    logic [FILL_W-1:0]     w_sum;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic [BYTE_W-1:0]     rdata;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign m_xfer     = r_m_valid && i_m_tready;

    assign seg     = i_s_tdata[SEG_W-1:0];
    assign payload = i_s_tdata[SEG_W +: PAYLOAD_W];
    assign restart = (seg == '0);

    // segment zero restarts before the sequence check
    always_comb begin
        eff_fill  = restart ? '0 : r_fill;
        eff_exp   = restart ? '0 : r_exp;
        eff_asm   = restart || r_asm;
        seg_match = eff_asm && ({1'b0, seg} == eff_exp);
        sum       = SUM_W'(eff_fill) + SUM_W'(CHUNK_BYTES);
        fits      = (sum <= SUM_W'(BUFFER_BYTES));
        enough    = (sum >= SUM_W'(MESSAGE_BYTES));
    end

    assign we    = (r_state == S_WRITE);
    assign w_sum = r_base + FILL_W'(r_k);
    assign waddr = w_sum[ADDR_W-1:0];
    assign raddr = ADDR_W'(r_idx);

    cansr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_payload[BYTE_W-1:0]),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_exp     <= '0;
            r_asm     <= 1'b0;
            r_emit    <= 1'b0;
            r_k       <= '0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_fill <= eff_fill;
                        r_exp  <= eff_exp;
                        r_asm  <= eff_asm;
                        if (seg_match) begin
                            if (!fits) begin
                                // overflow abandons the message
                                r_asm <= 1'b0;
                            end else begin
                                r_base    <= eff_fill;
                                r_payload <= payload;
                                r_k       <= '0;
                                r_fill    <= FILL_W'(sum);
                                r_exp     <= eff_exp + EXP_W'(1);
                                r_emit    <= i_s_tlast && enough;
                                if (i_s_tlast) begin
                                    r_asm <= 1'b0;
                                end
                                r_state <= S_WRITE;
                            end
                        end
                    end
                end
                S_WRITE: begin
                    r_payload <= r_payload >> BYTE_W;
                    r_k       <= r_k + KCNT_W'(1);
                    if (r_k == KCNT_W'(CHUNK_BYTES - 1)) begin
                        r_idx   <= '0;
                        r_state <= r_emit ? S_READ : S_IDLE;
                    end
                end
                S_READ: begin
                    // read address is presented this cycle, data lands next cycle
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_m_valid <= 1'b1;
                    r_m_byte  <= rdata;
                    r_m_idx   <= r_idx;
                    r_m_last  <= (r_idx == IDX_W'(MESSAGE_BYTES - 1));
                    r_state   <= S_HOLD;
                end
                S_HOLD: begin
                    if (m_xfer) begin
                        r_m_valid <= 1'b0;
                        if (r_m_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - BYTE_W - IDX_W){1'b0}}, r_m_idx, r_m_byte};
    assign o_m_tlast  = r_m_last;

    // no frame is taken while a byte is waiting on the output
    a_no_intake_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("frame accepted while output byte pending");

    // gathered length never passes the store size
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(BUFFER_BYTES))
        else $error("fill length beyond store size");

    // the final byte transfer frees the input side on the next cycle
    a_final_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_xfer && o_m_tlast) |=> o_s_tready)
        else $error("input not ready after final byte");

    // the last flag only rides on the final message position
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (r_m_idx == IDX_W'(MESSAGE_BYTES - 1)))
        else $error("tlast on wrong byte index");
endmodule
`default_nettype wire

// ===== hw/rtl/cansr_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// standalone, no package dependencies
`default_nettype none
module cansr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for can_segment_reassembler: frame streams in, message bytes out
// predicts each emitted byte from its own copy of the reassembly state
// depends on cansr_pkg and the can_segment_reassembler rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cansr_pkg::*;

    localparam int STALL_PCT     = 26;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_FRAMES = 56;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  index;
        logic              final_flag;
    } msg_byte_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    // predicted reassembly state
    logic [BYTE_W-1:0] asm_store [BUFFER_BYTES];
    int unsigned       fill_len;
    logic [EXP_W-1:0]  next_seg;
    bit                assembling;

    msg_byte_t pending_bytes [$];
    bit        steady;
    int        error_count;
    int        frames_used;
    int        bytes_checked;
    int        messages_built;
    int        overflows;
    int        cycle_count;

    can_segment_reassembler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // receiver backpressure, off while steady is set
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // one frame through the predicted state; used is set when the frame is not ignored
    task automatic reassemble_frame(input logic last, input logic [SEG_W-1:0] seg,
                                    input logic [PAYLOAD_W-1:0] pay, output bit used);
        msg_byte_t b;
        used = 1'b0;
        if (seg == '0) begin
            assembling = 1'b1;
            fill_len   = 0;
            next_seg   = '0;
            used       = 1'b1;
        end
        if (!assembling || {1'b0, seg} != next_seg)
            return;
        used = 1'b1;
        if (fill_len + CHUNK_BYTES > BUFFER_BYTES) begin
            assembling = 1'b0;
            overflows++;
            return;
        end
        for (int k = 0; k < CHUNK_BYTES; k++)
            asm_store[fill_len + k] = pay[BYTE_W*k +: BYTE_W];
        fill_len += CHUNK_BYTES;
        next_seg++;
        if (last) begin
            assembling = 1'b0;
            if (fill_len >= MESSAGE_BYTES) begin
                messages_built++;
                for (int k = 0; k < MESSAGE_BYTES; k++) begin
                    b.data       = asm_store[k];
                    b.index      = k[IDX_W-1:0];
                    b.final_flag = (k == MESSAGE_BYTES - 1);
                    pending_bytes.push_back(b);
                end
            end
        end
    endtask

    // valid stays high after a transfer so back-to-back frames need no bubble
    task automatic send_frame(input logic last, input logic [SEG_W-1:0] seg,
                              input logic [PAYLOAD_W-1:0] pay);
        logic [IN_TDATA_W-1:0] word;
        bit used;
        word = '0;
        word[SEG_W-1:0] = seg;
        word[SEG_W +: PAYLOAD_W] = pay;
        if (!steady && $urandom_range(0, 99) < STALL_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < STALL_PCT) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        reassemble_frame(last, seg, pay, used);
        if (used) frames_used++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [PAYLOAD_W-1:0] random_payload();
        return PAYLOAD_W'({$urandom, $urandom});
    endfunction

    // compare every transfer on the master side with the oldest predicted byte
    always @(posedge i_clk) begin
        msg_byte_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte 0x%02h index %0d",
                                          o_m_tdata[BYTE_W-1:0],
                                          o_m_tdata[BYTE_W +: IDX_W]));
            end else begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (o_m_tdata[BYTE_W-1:0] !== want.data)
                    report_mismatch($sformatf("byte %0d: data 0x%02h, want 0x%02h",
                                              want.index, o_m_tdata[BYTE_W-1:0], want.data));
                if (o_m_tdata[BYTE_W +: IDX_W] !== want.index)
                    report_mismatch($sformatf("byte index %0d, want %0d",
                                              o_m_tdata[BYTE_W +: IDX_W], want.index));
                if (o_m_tlast !== want.final_flag)
                    report_mismatch($sformatf("byte %0d: tlast %b, want %b",
                                              want.index, o_m_tlast, want.final_flag));
            end
        end
    end

    task automatic test_idle_frames();
        send_frame(1'b0, 7'h7F, {PAYLOAD_W{1'b1}});
        send_frame(1'b1, 7'd1, '0);
        send_frame(1'b1, 7'd5, random_payload());
    endtask

    // restart mid-message, an out-of-order frame, then a full message
    task automatic test_restart_and_order();
        send_frame(1'b0, 7'd0, random_payload());
        send_frame(1'b0, 7'd1, random_payload());
        send_frame(1'b0, 7'd0, {PAYLOAD_W{1'b1}});
        send_frame(1'b0, 7'd5, random_payload());
        send_frame(1'b0, 7'd1, '0);
        send_frame(1'b0, 7'd2, random_payload());
        send_frame(1'b0, 7'd3, {PAYLOAD_W{1'b1}});
        send_frame(1'b1, 7'd4, random_payload());
    endtask

    task automatic test_short_message();
        send_frame(1'b1, 7'd0, random_payload());
    endtask

    // nine segments fill 63 bytes, the tenth does not fit
    task automatic test_overflow();
        for (int s = 0; s < 10; s++)
            send_frame(1'b0, s[SEG_W-1:0], random_payload());
        send_frame(1'b1, 7'd10, random_payload());
        wait_drained();
    endtask

    // mostly well-formed messages, with noise frames and broken sequences mixed in
    task automatic send_random_message();
        int pick;
        int nseg;
        int skip_at;
        logic [SEG_W-1:0] seg;
        logic last;
        pick = $urandom_range(0, 99);
        if (pick < 70)      nseg = $urandom_range(5, 9);
        else if (pick < 90) nseg = $urandom_range(1, 4);
        else                nseg = $urandom_range(10, 11);
        skip_at = ($urandom_range(0, 99) < 10) ? $urandom_range(1, nseg) : -1;
        for (int s = 0; s < nseg; s++) begin
            if ($urandom_range(0, 99) < 12)
                send_frame(1'($urandom_range(0, 1)), SEG_W'($urandom_range(0, 127)),
                           random_payload());
            seg  = (s == skip_at) ? SEG_W'(s + 1) : SEG_W'(s);
            last = (s == nseg - 1) && ($urandom_range(0, 99) < 95);
            send_frame(last, seg, random_payload());
        end
    endtask

    task automatic test_random_messages(input int frames);
        int target;
        target = frames_used + frames;
        while (frames_used < target) send_random_message();
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (4) begin
            for (int s = 0; s < 6; s++)
                send_frame(s == 5, s[SEG_W-1:0], random_payload());
        end
        steady = 1'b0;
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_s_tvalid     <= 1'b0;
        i_s_tdata      <= '0;
        i_s_tlast      <= 1'b0;
        i_m_tready     <= 1'b0;
        steady         = 1'b0;
        error_count    = 0;
        frames_used    = 0;
        bytes_checked  = 0;
        messages_built = 0;
        overflows      = 0;
        fill_len       = 0;
        next_seg       = '0;
        assembling     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_frames();
        test_restart_and_order();
        test_short_message();
        test_overflow();
        test_random_messages(RANDOM_FRAMES / 2);
        test_back_to_back();
        test_random_messages(RANDOM_FRAMES / 2);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d frames in use, %0d messages, %0d overflows",
                 frames_used, messages_built, overflows);
        $display("checked %0d message bytes, %0d mismatches", bytes_checked, error_count);
        if (error_count == 0 && pending_bytes.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
